/* hw/rtl/shared_tick_timer_bank_unit_defines.svh */
// Assertion helpers for the shared tick timer bank.
// All checks sample on the rising edge of clk_i and are off while rst_ni is low.
`ifndef SHARED_TICK_TIMER_BANK_UNIT_DEFINES_SVH
`define SHARED_TICK_TIMER_BANK_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define STTB_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("sttb assertion failed");
`define STTB_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sttb implication failed");
`else
`define STTB_ASSERT(label, prop)
`define STTB_ASSERT_IMPLIES(label, ante, cons)
`endif

`endif

/* hw/rtl/sttb_pkg.sv */
`default_nettype none

package sttb_pkg;

  // Request kinds carried on the slave-side tuser
  typedef enum logic [1:0] {
    REQ_TICK    = 2'd0,
    REQ_RESTART = 2'd1,
    REQ_FREEZE  = 2'd2,
    REQ_POLL    = 2'd3
  } req_e;

  localparam int unsigned TICK_W   = 32;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned MASK_W   = 16;
  localparam int unsigned CNT_W    = 8;
  localparam int unsigned S_USER_W = 2;
  localparam int unsigned S_DATA_W = 40;
  localparam int unsigned M_DATA_W = 64;

endpackage

`default_nettype wire

/* hw/rtl/shared_tick_timer_bank_unit.sv */
// A tick walks every timer entry in S_WALK and then moves its result out in S_EMIT; restart,
//   freeze and poll pass S_MODIFY then S_EMIT (only S_EMIT for an index beyond the bank).
// One request at a time: a new one is taken only in S_IDLE, after the last result has moved to
//   the output register; the walk does one read-modify-write per entry per cycle.
// Reset: asynchronous, active low; per-entry valid flops clear at once, so every timer
//   reads as all zero after reset and no clearing pass is needed.
`default_nettype none
`include "shared_tick_timer_bank_unit_defines.svh"

module shared_tick_timer_bank_unit #(
  parameter int NUM_TIMERS  = 16,
  parameter int FIRED_WIDTH = 8
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // slave side
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: timer_index[3:0], tick_value[35:4], cyclic_mode[36], zero pad [39:37]
  input  wire logic [sttb_pkg::S_DATA_W-1:0]  s_axis_tdata,
  // tuser: req_type[1:0]
  input  wire logic [sttb_pkg::S_USER_W-1:0]  s_axis_tuser,
  // master side
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // tdata: expired_mask[15:0], has_fired[16], fired_count[24:17], timer_running[25],
  //        ticks_left[57:26], zero pad [63:58]
  output logic [sttb_pkg::M_DATA_W-1:0]       m_axis_tdata
);
  import sttb_pkg::*;

  localparam int AddrW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CntW  = $clog2(NUM_TIMERS + 1);
  localparam logic [8:0] NumT = 9'(NUM_TIMERS);

  // One memory word per timer
  typedef struct packed {
    logic [TICK_W-1:0]      rem;
    logic                   run;
    logic                   cyc;
    logic [TICK_W-1:0]      period;
    logic [FIRED_WIDTH-1:0] fired;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_MODIFY,
    S_EMIT
  } state_e;

  state_e            state_q;
  req_e              req_q;
  logic [IDX_W-1:0]  idx_q;
  logic              idx_ok_q;
  logic [TICK_W-1:0] val_q;
  logic              cyc_q;
  logic [CntW-1:0]   proc_q;

  // Result being built, then moved to the output register
  logic [MASK_W-1:0] res_mask_q;
  logic              res_has_q;
  logic [CNT_W-1:0]  res_cnt_q;
  logic              res_run_q;
  logic [TICK_W-1:0] res_ticks_q;

  logic                m_tvalid_q;
  logic [M_DATA_W-1:0] m_tdata_q;
  logic                emit_go;

  // Timer memory with per-entry valid flops
  entry_t                 mem [NUM_TIMERS];
  entry_t                 rd_data_q;
  logic                   rd_vld_q;
  logic [NUM_TIMERS-1:0]  vld_q;

  logic              in_acc;
  req_e              in_req;
  logic [IDX_W-1:0]  in_idx;
  logic [8:0]        in_idx9;
  logic              in_ok;
  logic [AddrW-1:0]  in_addr;

  logic              mem_re;
  logic              mem_we;
  logic [AddrW-1:0]  rd_addr;
  logic [AddrW-1:0]  wr_addr;
  logic [CntW-1:0]   proc_nxt;
  logic              walk_last;

  entry_t            ent_cur;
  entry_t            ent_new;
  logic              tick_hit;
  logic [MASK_W-1:0] mask_bit;
  logic              walk_match;
  logic              poll_has;
  logic [CNT_W-1:0]  poll_cnt;
  logic [31:0]       fired32;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign in_req  = req_e'(s_axis_tuser);
  assign in_idx  = s_axis_tdata[IDX_W-1:0];
  assign in_idx9 = 9'(in_idx);
  assign in_ok   = in_idx9 < NumT;
  assign in_addr = in_idx9[AddrW-1:0];

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;

  // The finished result moves to the output register once that register is free
  assign emit_go = (state_q == S_EMIT) && (!m_tvalid_q || m_axis_tready);

  assign proc_nxt  = proc_q + 1'b1;
  assign walk_last = (proc_q == CntW'(NUM_TIMERS - 1));

  // Read port: first entry (or the addressed one) on accept, next entry during the walk
  always_comb begin
    mem_re  = 1'b0;
    rd_addr = proc_nxt[AddrW-1:0];
    if (state_q == S_IDLE) begin
      mem_re  = in_acc;
      rd_addr = (in_req == REQ_TICK) ? '0 : in_addr;
    end else if (state_q == S_WALK) begin
      mem_re  = !walk_last;
    end
  end

  // Write back the entry whose data arrived this cycle
  assign mem_we  = (state_q == S_WALK) || (state_q == S_MODIFY);
  assign wr_addr = proc_q[AddrW-1:0];

  assign ent_cur = rd_vld_q ? rd_data_q : '0;

  always_comb begin
    ent_new  = ent_cur;
    tick_hit = 1'b0;
    case (req_q)
      REQ_TICK: begin
        if (ent_cur.run) begin
          ent_new.rem = ent_cur.rem - 1'b1;
          if (ent_new.rem == '0) begin
            tick_hit = 1'b1;
            if (ent_cur.cyc) begin
              // saturate the fired count, then reload from the stored period
              if (ent_cur.fired != '1) begin
                ent_new.fired = ent_cur.fired + 1'b1;
              end
              ent_new.rem = ent_cur.period + 1'b1;
              ent_new.run = (ent_cur.period != '0) && !ent_cur.period[TICK_W-1];
            end else begin
              ent_new.run = 1'b0;
            end
          end
        end
      end
      REQ_RESTART: begin
        // a zero or negative wait still loads, but leaves the timer stopped
        ent_new.rem    = val_q + 1'b1;
        ent_new.run    = (val_q != '0) && !val_q[TICK_W-1];
        ent_new.cyc    = cyc_q;
        ent_new.period = val_q;
      end
      REQ_FREEZE: begin
        ent_new.run = 1'b0;
      end
      REQ_POLL: begin
        ent_new.fired = '0;
      end
      default: begin
        ent_new = ent_cur;
      end
    endcase
  end

  assign fired32  = 32'(ent_cur.fired);
  assign poll_has = (ent_cur.fired != '0);
  assign poll_cnt = (fired32 > 32'd255) ? '1 : fired32[CNT_W-1:0];

  // Only the first sixteen timers show up in the mask
  assign mask_bit   = (tick_hit && (32'(proc_q) < 32'(MASK_W))) ?
                      (MASK_W'(1) << proc_q) : '0;
  assign walk_match = idx_ok_q && (32'(proc_q) == 32'(idx_q));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= ent_new;
    end
    if (mem_re) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (mem_we) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (mem_re) begin
        rd_vld_q <= vld_q[rd_addr];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      req_q       <= REQ_TICK;
      idx_q       <= '0;
      idx_ok_q    <= 1'b0;
      val_q       <= '0;
      cyc_q       <= 1'b0;
      proc_q      <= '0;
      res_mask_q  <= '0;
      res_has_q   <= 1'b0;
      res_cnt_q   <= '0;
      res_run_q   <= 1'b0;
      res_ticks_q <= '0;
      m_tvalid_q  <= 1'b0;
      m_tdata_q   <= '0;
    end else begin
      // drop the output once taken, unless a new result loads it this cycle
      if (m_tvalid_q && m_axis_tready && !emit_go) begin
        m_tvalid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            req_q       <= in_req;
            idx_q       <= in_idx;
            idx_ok_q    <= in_ok;
            val_q       <= s_axis_tdata[IDX_W +: TICK_W];
            cyc_q       <= s_axis_tdata[IDX_W + TICK_W];
            res_mask_q  <= '0;
            res_has_q   <= 1'b0;
            res_cnt_q   <= '0;
            res_run_q   <= 1'b0;
            res_ticks_q <= '0;
            if (in_req == REQ_TICK) begin
              proc_q  <= '0;
              state_q <= S_WALK;
            end else begin
              proc_q  <= CntW'(in_addr);
              // an index beyond the bank touches nothing and reports zeros
              state_q <= in_ok ? S_MODIFY : S_EMIT;
            end
          end
        end
        S_WALK: begin
          res_mask_q <= res_mask_q | mask_bit;
          if (walk_match) begin
            res_run_q   <= ent_new.run;
            res_ticks_q <= ent_new.rem;
          end
          proc_q <= proc_nxt;
          if (walk_last) begin
            state_q <= S_EMIT;
          end
        end
        S_MODIFY: begin
          res_run_q   <= ent_new.run;
          res_ticks_q <= ent_new.rem;
          if (req_q == REQ_POLL) begin
            res_has_q <= poll_has;
            res_cnt_q <= poll_cnt;
          end
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          // hold the result until the output register is free
          if (emit_go) begin
            m_tdata_q  <= M_DATA_W'({res_ticks_q, res_run_q, res_cnt_q, res_has_q,
                                     res_mask_q});
            m_tvalid_q <= 1'b1;
            state_q    <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  `STTB_ASSERT_IMPLIES(a_emit_loads, emit_go, ##1 m_tvalid_q && (state_q == S_IDLE))
  `STTB_ASSERT_IMPLIES(a_walk_in_range, state_q == S_WALK, 32'(proc_q) < 32'(NUM_TIMERS))
  `STTB_ASSERT_IMPLIES(a_has_matches_cnt, m_tvalid_q, m_tdata_q[16] == (m_tdata_q[24:17] != '0))
  `STTB_ASSERT_IMPLIES(a_mask_in_bank, m_tvalid_q, (32'(m_tdata_q[15:0]) >> NUM_TIMERS) == 32'd0)

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
  import sttb_pkg::*;

  localparam int NUM_TIMERS  = 16;
  localparam int FIRED_MAX   = 255;
  localparam int QUIET_LIMIT = 5000;
  localparam int RANDOM_ITEMS_PER_PHASE = 370;

  // Result fields, highest first, so the struct lines up with m_axis_tdata[57:0]
  typedef struct packed {
    logic [31:0] ticks_left;
    logic        timer_running;
    logic [7:0]  fired_count;
    logic        has_fired;
    logic [15:0] expired_mask;
  } timer_status_t;

  // One directed request; status is used as typed only where typed is set
  typedef struct {
    req_e          req;
    logic [3:0]    idx;
    logic [31:0]   val;
    logic          cyc;
    bit            typed;
    timer_status_t status;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata  = '0;
  logic [S_USER_W-1:0] s_axis_tuser  = REQ_TICK;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;

  // Shadow copy of the timer bank
  logic [31:0] count_left [NUM_TIMERS];
  logic        run_flag   [NUM_TIMERS];
  logic        cyc_flag   [NUM_TIMERS];
  logic [31:0] period     [NUM_TIMERS];
  logic [7:0]  fire_cnt   [NUM_TIMERS];

  timer_status_t pending_status_q [$];
  timer_status_t got_status;
  timer_status_t want_status;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int err_count      = 0;
  int results_seen   = 0;
  int requests_sent  = 0;
  int ticks_sent     = 0;
  int expiries_seen  = 0;
  int quiet_cycles   = 0;

  always #5 clk_i = ~clk_i;

  shared_tick_timer_bank_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Reload a timer; a zero or negative wait still loads, but leaves it stopped
  function automatic void load_timer(int k, logic [31:0] v);
    count_left[k] = v + 32'd1;
    run_flag[k]   = (v != 32'd0) && !v[31];
  endfunction

  // Apply one request to the shadow bank and return the status it yields
  function automatic timer_status_t advance_bank(req_e req, logic [3:0] idx,
                                                 logic [31:0] val, logic cyc);
    timer_status_t st;
    int k;
    st = '0;
    case (req)
      REQ_TICK: begin
        for (k = 0; k < NUM_TIMERS; k++) begin
          if (run_flag[k]) begin
            count_left[k] = count_left[k] - 32'd1;
            if (count_left[k] == 32'd0) begin
              st.expired_mask[k] = 1'b1;
              if (cyc_flag[k]) begin
                // Saturate the fired count, then retrigger from the stored period
                if (fire_cnt[k] != 8'(FIRED_MAX)) fire_cnt[k] = fire_cnt[k] + 8'd1;
                load_timer(k, period[k]);
              end else begin
                run_flag[k] = 1'b0;
              end
            end
          end
        end
      end
      REQ_RESTART: begin
        cyc_flag[idx] = cyc;
        period[idx]   = val;
        load_timer(int'(idx), val);
      end
      REQ_FREEZE: begin
        run_flag[idx] = 1'b0;
      end
      default: begin
        st.has_fired   = (fire_cnt[idx] != 8'd0);
        st.fired_count = fire_cnt[idx];
        fire_cnt[idx]  = 8'd0;
      end
    endcase
    st.timer_running = run_flag[idx];
    st.ticks_left    = count_left[idx];
    return st;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch in result %0d, %s: got 0x%08h, want 0x%08h",
             results_seen, field, got, want);
    err_count++;
  endtask

  // Hold one request on the slave side until it is taken, then record the
  // status it must produce and optionally idle the sender for a while.
  task automatic send_request(req_e req, logic [3:0] idx, logic [31:0] val, logic cyc,
                              bit typed, timer_status_t typed_status);
    timer_status_t model_status;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {3'b000, cyc, val, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    model_status = advance_bank(req, idx, val, cyc);
    pending_status_q.push_back(typed ? typed_status : model_status);
    requests_sent++;
    if (req == REQ_TICK) ticks_sent++;
    expiries_seen += $countones(model_status.expired_mask);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // Directed requests: reset state, one-shot and cyclic expiry, failed restarts
  // at zero and at the negative extremes, the largest positive wait, freeze,
  // poll-and-clear, and finally a fast cyclic timer on index 15 that the random
  // part leaves alone so that its fired count saturates.
  dir_row_t dir_tab [0:23] = '{
    '{REQ_POLL,    4'd0,  32'h0000_0000, 1'b0, 1'b1, {32'd0, 1'b0, 8'd0, 1'b0, 16'h0000}},
    '{REQ_TICK,    4'd0,  32'hFFFF_FFFF, 1'b1, 1'b1, {32'd0, 1'b0, 8'd0, 1'b0, 16'h0000}},
    '{REQ_RESTART, 4'd0,  32'h0000_0001, 1'b0, 1'b1, {32'd2, 1'b1, 8'd0, 1'b0, 16'h0000}},
    '{REQ_TICK,    4'd0,  32'h0000_0000, 1'b0, 1'b1, {32'd1, 1'b1, 8'd0, 1'b0, 16'h0000}},
    '{REQ_TICK,    4'd0,  32'h0000_0000, 1'b0, 1'b1, {32'd0, 1'b0, 8'd0, 1'b0, 16'h0001}},
    '{REQ_POLL,    4'd0,  32'h0000_0000, 1'b0, 1'b1, {32'd0, 1'b0, 8'd0, 1'b0, 16'h0000}},
    '{REQ_RESTART, 4'd1,  32'h0000_0000, 1'b1, 1'b1, {32'd1, 1'b0, 8'd0, 1'b0, 16'h0000}},
    '{REQ_RESTART, 4'd2,  32'hFFFF_FFFF, 1'b0, 1'b1, {32'd0, 1'b0, 8'd0, 1'b0, 16'h0000}},
    '{REQ_RESTART, 4'd3,  32'h8000_0000, 1'b1, 1'b1,
      {32'h8000_0001, 1'b0, 8'd0, 1'b0, 16'h0000}},
    '{REQ_RESTART, 4'd4,  32'h7FFF_FFFF, 1'b1, 1'b1,
      {32'h8000_0000, 1'b1, 8'd0, 1'b0, 16'h0000}},
    '{REQ_FREEZE,  4'd4,  32'h0000_0000, 1'b0, 1'b1,
      {32'h8000_0000, 1'b0, 8'd0, 1'b0, 16'h0000}},
    '{REQ_RESTART, 4'd15, 32'h0000_0002, 1'b1, 1'b1, {32'd3, 1'b1, 8'd0, 1'b0, 16'h0000}},
    '{REQ_RESTART, 4'd8,  32'h0000_0001, 1'b1, 1'b0, '0},
    '{REQ_TICK,    4'd15, 32'h5555_5555, 1'b0, 1'b0, '0},
    '{REQ_TICK,    4'd8,  32'hAAAA_AAAA, 1'b1, 1'b0, '0},
    '{REQ_TICK,    4'd15, 32'h0000_0000, 1'b0, 1'b0, '0},
    '{REQ_POLL,    4'd15, 32'h0000_0000, 1'b0, 1'b0, '0},
    '{REQ_POLL,    4'd15, 32'h0000_0000, 1'b0, 1'b0, '0},
    '{REQ_FREEZE,  4'd8,  32'h0000_0000, 1'b0, 1'b0, '0},
    '{REQ_TICK,    4'd8,  32'h0000_0000, 1'b0, 1'b0, '0},
    '{REQ_POLL,    4'd8,  32'h0000_0000, 1'b0, 1'b0, '0},
    '{REQ_RESTART, 4'd6,  32'h0000_0003, 1'b0, 1'b0, '0},
    '{REQ_FREEZE,  4'd15, 32'h0000_0000, 1'b0, 1'b0, '0},
    '{REQ_RESTART, 4'd15, 32'h0000_0001, 1'b1, 1'b1, {32'd2, 1'b1, 8'd0, 1'b0, 16'h0000}}
  };

  // Compare every result transaction with the oldest pending status, and
  // stall the master side at the rate of the current phase.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_status = m_axis_tdata[57:0];
      if (pending_status_q.size() == 0) begin
        report_mismatch("unexpected result", got_status.ticks_left, 32'd0);
      end else begin
        want_status = pending_status_q.pop_front();
        if (got_status.expired_mask != want_status.expired_mask)
          report_mismatch("expired_mask", 32'(got_status.expired_mask),
                          32'(want_status.expired_mask));
        if (got_status.has_fired != want_status.has_fired)
          report_mismatch("has_fired", 32'(got_status.has_fired),
                          32'(want_status.has_fired));
        if (got_status.fired_count != want_status.fired_count)
          report_mismatch("fired_count", 32'(got_status.fired_count),
                          32'(want_status.fired_count));
        if (got_status.timer_running != want_status.timer_running)
          report_mismatch("timer_running", 32'(got_status.timer_running),
                          32'(want_status.timer_running));
        if (got_status.ticks_left != want_status.ticks_left)
          report_mismatch("ticks_left", got_status.ticks_left, want_status.ticks_left);
      end
      results_seen++;
    end
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Count cycles in which neither side completes a transaction
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("no transaction for %0d cycles, %0d results still pending",
             QUIET_LIMIT, pending_status_q.size());
    $display("[shared_tick_timer_bank_unit] ERROR");
    $finish;
  end

  initial begin
    int phase;
    int n;
    int r;
    int send_pct [4];
    int recv_pct [4];
    req_e        req;
    logic [3:0]  idx;
    logic [31:0] val;

    // Idle profiles: none, sender mostly idle, receiver mostly stalled, both
    send_pct = '{0, 86, 0, 32};
    recv_pct = '{0, 0, 86, 32};

    for (n = 0; n < NUM_TIMERS; n++) begin
      count_left[n] = '0;
      run_flag[n]   = 1'b0;
      cyc_flag[n]   = 1'b0;
      period[n]     = '0;
      fire_cnt[n]   = '0;
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i])
      send_request(dir_tab[i].req, dir_tab[i].idx, dir_tab[i].val, dir_tab[i].cyc,
                   dir_tab[i].typed, dir_tab[i].status);

    // Random traffic on timers 0..14; timer 15 keeps firing in the background
    for (phase = 0; phase < 4; phase++) begin
      send_idle_pct  = send_pct[phase];
      recv_stall_pct = recv_pct[phase];
      for (n = 0; n < RANDOM_ITEMS_PER_PHASE; n++) begin
        r   = $urandom_range(99);
        req = (r < 40) ? REQ_TICK : (r < 65) ? REQ_RESTART : (r < 75) ? REQ_FREEZE : REQ_POLL;
        idx = 4'($urandom_range(14));
        val = $urandom;
        if (req == REQ_RESTART) begin
          // Favor short waits so timers actually expire between restarts
          r = $urandom_range(99);
          if (r < 50)      val = 32'($urandom_range(5, 1));
          else if (r < 60) val = 32'($urandom_range(40, 6));
          else if (r < 75) val = -32'($urandom_range(3));
          else if (r < 85) begin
            case ($urandom_range(2))
              0:       val = 32'h7FFF_FFFF;
              1:       val = 32'h8000_0000;
              default: val = 32'hFFFF_FFFF;
            endcase
          end
        end
        send_request(req, idx, val, 1'($urandom_range(1)), 1'b0, '0);
      end
    end

    // Collect the saturated fired count of the background timer
    send_request(REQ_POLL, 4'd15, 32'd0, 1'b0, 1'b0, '0);
    s_axis_tvalid <= 1'b0;

    while (pending_status_q.size() != 0) @(posedge clk_i);
    repeat (NUM_TIMERS + 4) @(posedge clk_i);

    $display("covered %0d requests (%0d ticks, %0d timer expiries) over four idle profiles",
             requests_sent, ticks_sent, expiries_seen);
    $display("%0d results checked, %0d mismatches", results_seen, err_count);
    if (err_count == 0)
      $display("[shared_tick_timer_bank_unit] OK");
    else
      $display("[shared_tick_timer_bank_unit] ERROR");
    $finish;
  end

endmodule
